// ----- rtl/jeml_pkg.sv -----
// Package for the JPEG EXIF marker locator.
// Holds the scan phase type, verdict codes, marker constants and the result struct.
// No dependencies.
package jeml_pkg;

  localparam int POS_BITS_DEF = 32;

  localparam int VERDICT_W = 2;
  localparam int OFFSET_W  = 32;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  localparam logic [7:0] MK_PREFIX = 8'hFF;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_DQT    = 8'hDB;
  localparam logic [7:0] MK_APP1   = 8'hE1;
  localparam logic [7:0] MK_HI_MSK = 8'hF0;
  localparam logic [7:0] MK_APPN   = 8'hE0;

  typedef enum logic [2:0] {
    PH_START0 = 3'd0,
    PH_START1 = 3'd1,
    PH_SCAN   = 3'd2,
    PH_MARKER = 3'd3,
    PH_LENHI  = 3'd4,
    PH_LENLO  = 3'd5,
    PH_SKIP   = 3'd6,
    PH_DONE   = 3'd7
  } phase_t;

  typedef enum logic [VERDICT_W-1:0] {
    V_FOUND    = 2'd0,
    V_BADSTART = 2'd1,
    V_QUANT    = 2'd2,
    V_ENDED    = 2'd3
  } verdict_t;

  typedef struct packed {
    logic                valid;
    verdict_t            verdict;
    logic [OFFSET_W-1:0] offset;
  } scan_res_t;

endpackage

// ----- rtl/jeml_in_reg.sv -----
// Input register stage of the JPEG EXIF marker locator.
// Depends on jeml_pkg.
module jeml_in_reg
  import jeml_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       adv,
  output logic       held_valid,
  output logic [7:0] held_byte,
  output logic       held_last
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;

  // take a new request when empty or when the held one moves on this cycle
  assign in_tready = !valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
  end

  assign held_valid = valid_r;
  assign held_byte  = byte_r;
  assign held_last  = last_r;

endmodule

// ----- rtl/jeml_scan.sv -----
// Marker scanner state machine of the JPEG EXIF marker locator.
// Tracks phase, byte position, segment skip count; depends on jeml_pkg.
module jeml_scan
  import jeml_pkg::*;
#(
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic [7:0] b,
  input  logic      last,
  output scan_res_t res
);

  phase_t                   phase_r, phase_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [15:0]              skip_r, skip_nxt;
  logic [7:0]               lenhi_r, lenhi_nxt;

  logic        dec;
  verdict_t    dec_v;
  logic [15:0] seg_len;
  logic [63:0] pos_ext;
  logic [63:0] pos_m1;

  assign seg_len = {lenhi_r, b};
  assign pos_ext = 64'(pos_r);
  assign pos_m1  = pos_ext - 64'd1;

  // decision on the current byte
  always_comb begin
    dec   = 1'b0;
    dec_v = V_ENDED;
    unique case (phase_r)
      PH_START0: begin
        if (b != MK_PREFIX || last) begin
          dec   = 1'b1;
          dec_v = V_BADSTART;
        end
      end
      PH_START1: begin
        if (b != MK_SOI) begin
          dec   = 1'b1;
          dec_v = V_BADSTART;
        end
      end
      PH_MARKER: begin
        if (b == MK_DQT) begin
          dec   = 1'b1;
          dec_v = V_QUANT;
        end else if (b == MK_APP1) begin
          dec   = 1'b1;
          dec_v = V_FOUND;
        end
      end
      default: begin
        dec   = 1'b0;
        dec_v = V_ENDED;
      end
    endcase
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    skip_nxt  = skip_r;
    lenhi_nxt = lenhi_r;
    unique case (phase_r)
      PH_START0: phase_nxt = PH_START1;
      PH_START1: phase_nxt = PH_SCAN;
      PH_SCAN: begin
        if (b == MK_PREFIX) phase_nxt = PH_MARKER;
      end
      PH_MARKER: begin
        priority if ((b & MK_HI_MSK) == MK_APPN) phase_nxt = PH_LENHI;
        else if (b == MK_PREFIX)                 phase_nxt = PH_MARKER;
        else                                     phase_nxt = PH_SCAN;
      end
      PH_LENHI: begin
        lenhi_nxt = b;
        phase_nxt = PH_LENLO;
      end
      PH_LENLO: begin
        skip_nxt  = (seg_len < 16'd2) ? 16'd0 : seg_len - 16'd2;
        phase_nxt = (seg_len > 16'd2) ? PH_SKIP : PH_SCAN;
      end
      PH_SKIP: begin
        if (skip_r != 16'd0) skip_nxt = skip_r - 16'd1;
        if (skip_r <= 16'd1) phase_nxt = PH_SCAN;
      end
      PH_DONE: phase_nxt = PH_DONE;
      default: phase_nxt = PH_DONE;
    endcase
    if (dec) phase_nxt = PH_DONE;

    pos_nxt = (pos_r != '1) ? pos_r + 1'b1 : pos_r;

    if (last) begin
      phase_nxt = PH_START0;
      pos_nxt   = '0;
      skip_nxt  = 16'd0;
      lenhi_nxt = 8'd0;
    end
  end

  // result for this byte
  always_comb begin
    res = '0;
    if (adv) begin
      if (dec) begin
        res.valid   = 1'b1;
        res.verdict = dec_v;
        if (dec_v == V_FOUND) begin
          res.offset = (pos_r != '0) ? pos_m1[OFFSET_W-1:0] : '0;
        end
      end else if (last && phase_r != PH_DONE) begin
        res.valid   = 1'b1;
        res.verdict = V_ENDED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START0;
      pos_r   <= '0;
      skip_r  <= 16'd0;
      lenhi_r <= 8'd0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      skip_r  <= skip_nxt;
      lenhi_r <= lenhi_nxt;
    end
  end

  a_res_needs_adv: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> adv) else $error("result without a consumed byte");

  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.verdict != V_FOUND |-> res.offset == '0)
    else $error("nonzero offset on a non-found verdict");

  a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    adv && last |=> phase_r == PH_START0 && pos_r == '0)
    else $error("last byte did not rearm the scanner");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP |-> skip_r != 16'd0)
    else $error("skip phase with empty skip count");

endmodule

// ----- rtl/jeml_out_reg.sv -----
// Result register of the JPEG EXIF marker locator.
// Holds one verdict request until the sink takes it; depends on jeml_pkg.
module jeml_out_reg
  import jeml_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  scan_res_t              res,
  output logic                   can_take,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic                   valid_r;
  logic [OUT_TDATA_W-1:0] data_r;

  assign can_take = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_take) begin
      valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && res.valid) begin
      data_r <= {{(OUT_TDATA_W - VERDICT_W - OFFSET_W){1'b0}}, res.offset, res.verdict};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

// ----- rtl/jpeg_exif_marker_locator.sv -----
// A byte is held in the input register, and its verdict is then registered in the result register that drives out_*.
// Throughput: one byte per cycle; the scanner steps once per byte and the
// result register frees while its verdict is taken, so the stream never waits
// unless the sink holds out_tready low with a verdict pending.
// Reset (rst_n low, synchronous): scanner expects FF D8, position zero, both
// register stages empty.
module jpeg_exif_marker_locator
  import jeml_pkg::*;
#(
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                   in_tlast,   // end_of_image
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [1:0] verdict, [33:2] exif_offset, rest zero
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       held_last;
  logic       can_take;
  logic       adv;
  scan_res_t  res;

  // advance the held byte whenever the result register can absorb its verdict
  assign adv = held_valid && can_take;

  jeml_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .adv        (adv),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .held_last  (held_last)
  );

  // scan phase, position and segment skip; emits at most one verdict per request
  jeml_scan #(
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .b     (held_byte),
    .last  (held_last),
    .res   (res)
  );

  // hold the verdict until the sink takes it
  jeml_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .can_take   (can_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- bench/jpeg_exif_marker_locator_test.sv -----
// Self-checking bench for jpeg_exif_marker_locator: streams JPEG-like byte images
// and checks each verdict against a cycle-free scanner kept beside the block.
// Depends on rtl/jeml_pkg.sv and rtl/jpeg_exif_marker_locator.sv.
module jpeg_exif_marker_locator_test
  import jeml_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Position counter width as in the default build.
  localparam int POS_W = POS_BITS_DEF;
  localparam int RANDOM_BYTES = 1550;
  localparam longint CYCLE_LIMIT = 3_000_000;
  localparam int DIRECTED_ROWS = 27;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  jpeg_exif_marker_locator #(
    .POSITION_BITS(POS_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [7:0] data_byte
    .in_tlast  (in_tlast),   // end_of_image
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)   // [1:0] verdict, [33:2] exif_offset, [39:34] zero
  );

  // One verdict as the sink should see it.
  typedef struct {
    verdict_t    verdict;
    logic [31:0] offset;
  } verdict_rec_t;

  // One row of the directed table. Rows with has_fixed carry a verdict typed in by
  // hand; all other rows are checked against the scanner.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        has_fixed;
    verdict_t    verdict;
    logic [31:0] offset;
  } byte_row_t;

  localparam byte_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    // APP1 right after the start marker, decided on the final byte
    '{MK_PREFIX, 1'b0, 1'b0, V_FOUND,    32'd0},
    '{MK_SOI,    1'b0, 1'b0, V_FOUND,    32'd0},
    '{MK_PREFIX, 1'b0, 1'b0, V_FOUND,    32'd0},
    '{MK_APP1,   1'b1, 1'b1, V_FOUND,    32'd2},
    // bad first byte, then a silent closing byte
    '{8'h00,     1'b0, 1'b1, V_BADSTART, 32'd0},
    '{8'h00,     1'b1, 1'b0, V_FOUND,    32'd0},
    // stream that ends on its first byte
    '{MK_PREFIX, 1'b1, 1'b1, V_BADSTART, 32'd0},
    // bad second byte
    '{MK_PREFIX, 1'b0, 1'b0, V_FOUND,    32'd0},
    '{8'h00,     1'b0, 1'b1, V_BADSTART, 32'd0},
    '{MK_PREFIX, 1'b1, 1'b0, V_FOUND,    32'd0},
    // quantization table before any APP1
    '{MK_PREFIX, 1'b0, 1'b0, V_FOUND,    32'd0},
    '{MK_SOI,    1'b0, 1'b0, V_FOUND,    32'd0},
    '{MK_PREFIX, 1'b0, 1'b0, V_FOUND,    32'd0},
    '{MK_DQT,    1'b0, 1'b1, V_QUANT,    32'd0},
    '{8'h00,     1'b1, 1'b0, V_FOUND,    32'd0},
    // APP0 with a length below two, then a doubled prefix before APP1
    '{MK_PREFIX, 1'b0, 1'b0, V_FOUND,    32'd0},
    '{MK_SOI,    1'b0, 1'b0, V_FOUND,    32'd0},
    '{MK_PREFIX, 1'b0, 1'b0, V_FOUND,    32'd0},
    '{MK_APPN,   1'b0, 1'b0, V_FOUND,    32'd0},
    '{8'h00,     1'b0, 1'b0, V_FOUND,    32'd0},
    '{8'h01,     1'b0, 1'b0, V_FOUND,    32'd0},
    '{MK_PREFIX, 1'b0, 1'b0, V_FOUND,    32'd0},
    '{MK_PREFIX, 1'b0, 1'b0, V_FOUND,    32'd0},
    '{MK_APP1,   1'b1, 1'b1, V_FOUND,    32'd7},
    // image ends right after a marker prefix
    '{MK_PREFIX, 1'b0, 1'b0, V_FOUND,    32'd0},
    '{MK_SOI,    1'b0, 1'b0, V_FOUND,    32'd0},
    '{MK_PREFIX, 1'b1, 1'b1, V_ENDED,    32'd0}
  };

  // Scanner state, mirrors the block's state after each accepted byte.
  phase_t           sc_phase = PH_START0;
  logic [POS_W-1:0] sc_pos   = '0;
  logic [15:0]      sc_skip  = '0;
  logic [7:0]       sc_lenhi = '0;

  verdict_rec_t verdict_q[$];     // verdicts still owed by the block
  int           error_count = 0;
  longint       cycle_count = 0;
  bit           idle_off    = 1'b0; // suppress random gaps on both sides

  // Typed expectation travelling with the byte currently offered.
  logic        cur_fixed;
  verdict_t    cur_verdict;
  logic [31:0] cur_offset;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advance the scanner by one byte and report the verdict it yields, if any.
  task automatic scan_byte(input logic [7:0] b, input logic last, output bit has,
                           output verdict_t v, output logic [31:0] off);
    logic [15:0] seg_len;
    has = 1'b0;
    v   = V_FOUND;
    off = '0;
    case (sc_phase)
      PH_START0: begin
        if (b != MK_PREFIX || last) begin
          has = 1'b1;
          v   = V_BADSTART;
        end else begin
          sc_phase = PH_START1;
        end
      end
      PH_START1: begin
        if (b != MK_SOI) begin
          has = 1'b1;
          v   = V_BADSTART;
        end else begin
          sc_phase = PH_SCAN;
        end
      end
      PH_SCAN: begin
        if (b == MK_PREFIX) sc_phase = PH_MARKER;
      end
      PH_MARKER: begin
        if (b == MK_DQT) begin
          has = 1'b1;
          v   = V_QUANT;
        end else if (b == MK_APP1) begin
          has = 1'b1;
          v   = V_FOUND;
          // offset of the prefix byte, which sits one position back
          off = (sc_pos != '0) ? 32'(sc_pos - 1'b1) : '0;
        end else if ((b & MK_HI_MSK) == MK_APPN) begin
          sc_phase = PH_LENHI;
        end else if (b == MK_PREFIX) begin
          sc_phase = PH_MARKER;
        end else begin
          sc_phase = PH_SCAN;
        end
      end
      PH_LENHI: begin
        sc_lenhi = b;
        sc_phase = PH_LENLO;
      end
      PH_LENLO: begin
        seg_len = {sc_lenhi, b};
        if (seg_len < 16'd2) seg_len = 16'd2;
        sc_skip  = seg_len - 16'd2;
        sc_phase = (sc_skip != '0) ? PH_SKIP : PH_SCAN;
      end
      PH_SKIP: begin
        if (sc_skip != '0) sc_skip = sc_skip - 1'b1;
        if (sc_skip == '0) sc_phase = PH_SCAN;
      end
      default: ;
    endcase
    if (has) begin
      sc_phase = PH_DONE;
    end else if (last && sc_phase != PH_DONE) begin
      has = 1'b1;
      v   = V_ENDED;
    end
    if (sc_pos != '1) sc_pos = sc_pos + 1'b1;
    // end of image rearms the scanner
    if (last) begin
      sc_phase = PH_START0;
      sc_pos   = '0;
      sc_skip  = '0;
      sc_lenhi = '0;
    end
  endtask

  // Sample both channels at the rising edge: predict on each accepted request,
  // check each accepted verdict against the oldest one owed.
  always @(posedge clk) begin
    bit           has;
    verdict_t     v;
    logic [31:0]  off;
    verdict_rec_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        scan_byte(in_tdata, in_tlast, has, v, off);
        if (cur_fixed) verdict_q.push_back('{cur_verdict, cur_offset});
        else if (has) verdict_q.push_back('{v, off});
      end
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict %0d offset %0d", $realtime,
                   out_tdata[1:0], out_tdata[33:2]);
          error_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_tdata[1:0] != want.verdict) begin
            $display("%0t: verdict expected %0d actual %0d", $realtime,
                     want.verdict, out_tdata[1:0]);
            error_count++;
          end
          if (out_tdata[33:2] != want.offset) begin
            $display("%0t: exif_offset expected %0d actual %0d", $realtime,
                     want.offset, out_tdata[33:2]);
            error_count++;
          end
          if (out_tdata[39:34] != '0) begin
            $display("%0t: tdata pad expected 0 actual %0h", $realtime,
                     out_tdata[39:34]);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** jpeg_exif_marker_locator: FAILED **");
      $finish;
    end
  end

  // Sink: before each verdict, drop tready for a random gap, then
  // hold it high until a verdict is taken.
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = idle_off ? 0 : $urandom_range(0, 8);
      @(negedge clk);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Offer one byte after a random gap and hold it until the request is taken.
  // Keep tvalid high across back-to-back requests rather than toggling it.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic fixed,
                           input verdict_t fv, input logic [31:0] fo);
    int gap;
    gap = idle_off ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= b;
    in_tlast    <= last;
    cur_fixed   <= fixed;
    cur_verdict <= fv;
    cur_offset  <= fo;
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    logic [7:0]  img[$];
    logic [7:0]  mk;
    logic [15:0] seg_len;
    int          core_len;
    int          counted;
    int          nseg;
    int          kind;
    int          term;
    int          cut;

    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cur_fixed   = 1'b0;
    cur_verdict = V_FOUND;
    cur_offset  = '0;
    rst_n       = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table: extremes, every verdict and the corner cases.
    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].has_fixed,
                DIRECTED[i].verdict, DIRECTED[i].offset);

    // Random images, mostly well formed with random segments and a random ending.
    counted = 0;
    while (counted < RANDOM_BYTES) begin
      img.delete();
      idle_off = ($urandom_range(0, 6) == 0);
      if ($urandom_range(0, 4) == 0) begin
        // broken start: a few bytes that may or may not open with FF D8
        repeat ($urandom_range(1, 6)) img.push_back(8'($urandom));
        if ($urandom_range(0, 1) != 0) img[0] = MK_PREFIX;
        if (img.size() > 1 && $urandom_range(0, 1) != 0) img[1] = MK_SOI;
        core_len = img.size();
      end else begin
        img.push_back(MK_PREFIX);
        img.push_back(MK_SOI);
        nseg = $urandom_range(0, 3);
        for (int s = 0; s < nseg; s++) begin
          kind = $urandom_range(0, 9);
          if (kind <= 4) begin
            // APPn other than APP1, skipped by its length
            mk = MK_APPN | 8'($urandom_range(0, 15));
            if (mk == MK_APP1) mk = MK_APPN;
            case ($urandom_range(0, 9))
              0:       seg_len = 16'($urandom_range(0, 1));
              9:       seg_len = 16'($urandom_range(250, 600));
              default: seg_len = 16'($urandom_range(2, 24));
            endcase
            img.push_back(MK_PREFIX);
            img.push_back(mk);
            img.push_back(seg_len[15:8]);
            img.push_back(seg_len[7:0]);
            for (int k = 2; k < seg_len; k++) img.push_back(8'($urandom));
          end else if (kind <= 6) begin
            repeat ($urandom_range(1, 4)) img.push_back(8'($urandom_range(0, 254)));
          end else if (kind == 7) begin
            // other marker: rescanned as a plain byte
            do mk = 8'($urandom_range(0, 254));
            while (mk == MK_DQT || (mk & MK_HI_MSK) == MK_APPN);
            img.push_back(MK_PREFIX);
            img.push_back(mk);
          end else if (kind == 8) begin
            img.push_back(MK_PREFIX);
            img.push_back(MK_PREFIX);
          end else begin
            img.push_back(MK_PREFIX);
            img.push_back(8'h00);
          end
        end
        term = $urandom_range(0, 9);
        if (term <= 4) begin
          img.push_back(MK_PREFIX);
          img.push_back(MK_APP1);
        end else if (term <= 7) begin
          img.push_back(MK_PREFIX);
          img.push_back(MK_DQT);
        end
        core_len = img.size();
        // bytes after a decision are swallowed until end of image
        if (term <= 7) repeat ($urandom_range(0, 4)) img.push_back(8'($urandom));
        // cut some images short: inside a length, a segment or after a prefix
        if ($urandom_range(0, 3) == 0) begin
          cut = $urandom_range(1, img.size());
          while (img.size() > cut) void'(img.pop_back());
          if (core_len > cut) core_len = cut;
        end
      end
      counted += core_len;
      foreach (img[i]) send_byte(img[i], i == img.size() - 1, 1'b0, V_FOUND, '0);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    // Drain: wait for every owed verdict, then wait on for strays.
    wait (verdict_q.size() == 0);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("** jpeg_exif_marker_locator: PASSED **");
    end else begin
      $display("** jpeg_exif_marker_locator: FAILED **");
    end
    $finish;
  end

endmodule
